// File: src/bsfp_pkg.sv
package bsfp_pkg;

    // Field and counter widths, limits and the stuffing pattern length
    localparam int unsigned CNT_W        = 7;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned PAD_MAX      = 64;
    localparam int unsigned COUNT_MAX    = 127;
    localparam int unsigned PATTERN_ONES = 5;
    localparam int unsigned PROG_W       = 3;

    // Default depth of the command queue between front and back
    localparam int unsigned CMD_DEPTH = 4;

    // Kind codes on the result port
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_STUFF = 2'd1,
        KIND_PAD   = 2'd2
    } kind_t;

    // Back-end emit phase
    typedef enum logic [1:0] {
        PH_DATA,
        PH_STUFF,
        PH_PAD
    } phase_t;

    // One classified input bit: data, optional stuffed zero, then pad zeros
    typedef struct packed {
        logic             data_bit;
        logic             stuff;
        logic             last;
        logic [CNT_W-1:0] pad_cnt;
    } cmd_t;

endpackage

// File: src/bit_stuffer_with_frame_padding.sv
// An input bit enters the command queue, then the back-end word register that
// drives the result ports. One bit in and one word out per cycle while pop is
// held; stuffed and pad zeros each take an output word, during which the
// command queue (CMD_DEPTH entries) absorbs input until it fills.
// Reset: asynchronous, active low; clears match state, counters and queues,
// and sets padded_length to 64.
module bit_stuffer_with_frame_padding #(
    parameter int unsigned CMD_DEPTH = bsfp_pkg::CMD_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        padded_length_wr,
    input  logic [bsfp_pkg::CNT_W-1:0]  padded_length,
    input  logic                        push,
    output logic                        full,
    input  logic                        data_bit,
    input  logic                        frame_end,
    output logic                        empty,
    input  logic                        pop,
    output logic                        out_bit,
    output logic [bsfp_pkg::KIND_W-1:0] out_kind,
    output logic                        out_last
);
    import bsfp_pkg::*;

    cmd_t cmd;
    cmd_t q_data;
    logic accept;
    logic q_rd;
    logic q_empty;

    assign accept = push && !full;

    // Front: classify each bit, track pattern and frame length
    bsfp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .padded_length_wr (padded_length_wr),
        .padded_length    (padded_length),
        .accept           (accept),
        .data_bit         (data_bit),
        .frame_end        (frame_end),
        .cmd              (cmd)
    );

    // Command queue between front and back
    bsfp_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (accept),
        .wr_data (cmd),
        .rd      (q_rd),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    // Back: expand each command into output words
    bsfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .out_bit  (out_bit),
        .out_kind (out_kind),
        .out_last (out_last)
    );

    // Inserted zeros are always zero
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_kind == KIND_STUFF || out_kind == KIND_PAD)) |-> !out_bit)
        else $error("stuffed or pad word carries a one");

    // Padding runs without a gap until the frame's last word
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && out_kind == KIND_PAD && !out_last)
        |=> (!empty && out_kind == KIND_PAD))
        else $error("pad run broken before frame end");

    // Pad count never exceeds the max padded length, only on frame end
    a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (cmd.pad_cnt <= CNT_W'(PAD_MAX) && (cmd.last || cmd.pad_cnt == '0)))
        else $error("pad count out of range");

endmodule

// File: src/bsfp_front.sv
module bsfp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    padded_length_wr,
    input  logic [bsfp_pkg::CNT_W-1:0] padded_length,
    input  logic                    accept,
    input  logic                    data_bit,
    input  logic                    frame_end,
    output bsfp_pkg::cmd_t          cmd
);
    import bsfp_pkg::*;

    logic [CNT_W-1:0]  pad_len_reg;
    logic [CNT_W-1:0]  pad_len_next;
    logic [PROG_W-1:0] prog_reg;
    logic [PROG_W-1:0] prog_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              stuff;
    logic [CNT_W:0]    count_sum;
    logic [CNT_W-1:0]  count_after;
    logic [CNT_W-1:0]  pad_cnt;

    // Config register, clamped to the max pad length
    always_comb
    begin
        pad_len_next = pad_len_reg;
        if (padded_length_wr)
        begin
            if (padded_length > CNT_W'(PAD_MAX))
                pad_len_next = CNT_W'(PAD_MAX);
            else
                pad_len_next = padded_length;
        end
    end

    // Pattern tracking: a 0 then five 1s triggers a stuffed zero
    assign stuff = data_bit && (prog_reg == PROG_W'(PATTERN_ONES));

    always_comb
    begin
        prog_next = prog_reg;
        if (accept)
        begin
            if (frame_end)
                prog_next = '0;
            else if (!data_bit)
                prog_next = PROG_W'(1);
            else if (stuff)
                prog_next = '0;
            else if (prog_reg != '0)
                prog_next = prog_reg + PROG_W'(1);
        end
    end

    // Saturating output count and pad length for this frame
    assign count_sum   = {1'b0, count_reg} + (CNT_W+1)'(1) + {{CNT_W{1'b0}}, stuff};
    assign count_after = (count_sum > (CNT_W+1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX)
                                                             : count_sum[CNT_W-1:0];
    assign pad_cnt     = (frame_end && (count_after < pad_len_reg))
                         ? (pad_len_reg - count_after) : '0;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
            count_next = frame_end ? '0 : count_after;
    end

    always_comb
    begin
        cmd.data_bit = data_bit;
        cmd.stuff    = stuff;
        cmd.last     = frame_end;
        cmd.pad_cnt  = pad_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_len_reg <= CNT_W'(PAD_MAX);
            prog_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pad_len_reg <= pad_len_next;
            prog_reg    <= prog_next;
            count_reg   <= count_next;
        end
    end

endmodule

// File: src/bsfp_cmd_fifo.sv
module bsfp_cmd_fifo #(
    parameter int unsigned DEPTH = bsfp_pkg::CMD_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  bsfp_pkg::cmd_t wr_data,
    input  logic           rd,
    output bsfp_pkg::cmd_t rd_data,
    output logic           full,
    output logic           empty
);
    import bsfp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        cnt_next = cnt_reg + CW'(do_wr) - CW'(do_rd);
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: src/bsfp_back.sv
module bsfp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  bsfp_pkg::cmd_t              q_data,
    output logic                        q_rd,
    input  logic                        pop,
    output logic                        empty,
    output logic                        out_bit,
    output logic [bsfp_pkg::KIND_W-1:0] out_kind,
    output logic                        out_last
);
    import bsfp_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic             valid_reg;
    logic             valid_next;
    logic             bit_reg;
    logic             bit_next;
    logic             stuff_reg;
    logic             stuff_next;
    logic             last_reg;
    logic             last_next;
    logic [CNT_W-1:0] pad_reg;
    logic [CNT_W-1:0] pad_next;
    logic             final_word;
    logic             take;
    logic             load;

    // Word being shown is the final one of its command
    always_comb
    begin
        case (phase_reg)
            PH_DATA:  final_word = !stuff_reg && (pad_reg == '0);
            PH_STUFF: final_word = (pad_reg == '0);
            PH_PAD:   final_word = (pad_reg == CNT_W'(1));
            default:  final_word = 1'b1;
        endcase
    end

    assign take = valid_reg && pop;
    assign load = (!valid_reg || (take && final_word)) && !q_empty;
    assign q_rd = load;

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        bit_next   = bit_reg;
        stuff_next = stuff_reg;
        last_next  = last_reg;
        pad_next   = pad_reg;
        if (load)
        begin
            phase_next = PH_DATA;
            valid_next = 1'b1;
            bit_next   = q_data.data_bit;
            stuff_next = q_data.stuff;
            last_next  = q_data.last;
            pad_next   = q_data.pad_cnt;
        end
        else if (take)
        begin
            if (final_word)
                valid_next = 1'b0;
            else
            begin
                case (phase_reg)
                    PH_DATA:  phase_next = stuff_reg ? PH_STUFF : PH_PAD;
                    PH_STUFF: phase_next = PH_PAD;
                    PH_PAD:   pad_next   = pad_reg - CNT_W'(1);
                    default:  phase_next = PH_DATA;
                endcase
            end
        end
    end

    // Outputs
    always_comb
    begin
        empty    = !valid_reg;
        out_last = last_reg && final_word;
        case (phase_reg)
            PH_DATA:
            begin
                out_bit  = bit_reg;
                out_kind = KIND_DATA;
            end
            PH_STUFF:
            begin
                out_bit  = 1'b0;
                out_kind = KIND_STUFF;
            end
            PH_PAD:
            begin
                out_bit  = 1'b0;
                out_kind = KIND_PAD;
            end
            default:
            begin
                out_bit  = 1'b0;
                out_kind = KIND_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        bit_reg   <= bit_next;
        stuff_reg <= stuff_next;
        last_reg  <= last_next;
        pad_reg   <= pad_next;
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfp_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_ROWS     = 23;
    localparam int PHASE_ITEMS  = 3;
    localparam int LONG_FRAME   = 110;
    localparam int HOLD_AT_WORD = 60;

    // Row types of the directed table
    localparam logic ROW_BIT = 1'b0;
    localparam logic ROW_CFG = 1'b1;

    // Random frame styles
    localparam int FRAME_BIASED      = 0;
    localparam int FRAME_NOISE       = 1;
    localparam int FRAME_PATTERN_END = 2;
    localparam int FRAME_STUFFED     = 3;

    // Receiver stall modes
    localparam int RX_STREAM  = 0;
    localparam int RX_PATTERN = 1;
    localparam int RX_SPARSE  = 2;

    typedef struct packed {
        logic  value;
        kind_t kind;
        logic  last;
    } out_word_t;

    // typed = 1: expected words are read off the row (data, optional stuff, pads)
    typedef struct packed {
        logic             is_cfg;
        logic [CNT_W-1:0] cfg_val;
        logic             d;
        logic             fe;
        logic             typed;
        logic             t_stuff;
        logic [CNT_W-1:0] t_pad;
    } stim_row_t;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                padded_length_wr = 1'b0;
    logic [CNT_W-1:0]    padded_length    = '0;
    logic                push             = 1'b0;
    logic                data_bit         = 1'b0;
    logic                frame_end        = 1'b0;
    logic                pop              = 1'b0;
    logic                full;
    logic                empty;
    logic                out_bit;
    logic [KIND_W-1:0]   out_kind;
    logic                out_last;

    bit_stuffer_with_frame_padding u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .padded_length_wr (padded_length_wr),
        .padded_length    (padded_length),
        .push             (push),
        .full             (full),
        .data_bit         (data_bit),
        .frame_end        (frame_end),
        .empty            (empty),
        .pop              (pop),
        .out_bit          (out_bit),
        .out_kind         (out_kind),
        .out_last         (out_last)
    );

    // Directed table: extremes of the pad length, stuffing at frame end,
    // stuffed zero not counted toward the next match, oversized write
    stim_row_t dir_rows [NUM_ROWS] = '{
        '{ROW_BIT, 7'd0,   1'b1, 1'b1, 1'b1, 1'b0, 7'd63},
        '{ROW_BIT, 7'd0,   1'b0, 1'b1, 1'b1, 1'b0, 7'd63},
        '{ROW_CFG, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b1, 1'b1, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b0, 1'b0, 1'b1, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b1, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b1, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b1, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b1, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b1, 1'b1, 1'b1, 7'd0},
        '{ROW_BIT, 7'd0,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b1, 1'b0, 1'b0, 7'd0},
        '{ROW_CFG, 7'd127, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0},
        '{ROW_BIT, 7'd0,   1'b1, 1'b1, 1'b1, 1'b0, 7'd63}
    };

    // Stuffer model state
    logic [CNT_W-1:0]  pad_target  = CNT_W'(PAD_MAX);
    logic [PROG_W-1:0] ones_run    = '0;
    logic [CNT_W-1:0]  frame_words = '0;

    out_word_t expected_words [$];
    out_word_t pred_words [$];

    int mismatches    = 0;
    int words_checked = 0;
    int stuff_seen    = 0;
    int pad_seen      = 0;
    int frames_sent   = 0;
    int sat_frames    = 0;
    int bits_accepted = 0;
    int burst_left    = 0;
    int gap_max       = 6;

    always #6 clk = ~clk;

    // Hard stop
    initial
    begin
        #25ms;
        $display("Mismatches found");
        $finish;
    end

    // One output word of the model; at most PAD_MAX per input bit
    task automatic add_predicted(input logic b, input kind_t k);
        out_word_t w;
        if (pred_words.size() < PAD_MAX)
        begin
            w.value = b;
            w.kind  = k;
            w.last  = 1'b0;
            pred_words.push_back(w);
            if (frame_words < COUNT_MAX)
                frame_words = frame_words + 1'b1;
        end
    endtask

    // Stuff after 0 + five 1s, pad the frame to pad_target at frame end
    task automatic predict_stuffing(input logic d, input logic fe);
        logic stuffed;
        stuffed = 1'b0;
        pred_words.delete();
        add_predicted(d, KIND_DATA);
        if (!d)
            ones_run = PROG_W'(1);
        else if (ones_run == PATTERN_ONES)
        begin
            stuffed  = 1'b1;
            ones_run = '0;
        end
        else if (ones_run != 0)
            ones_run = ones_run + 1'b1;
        if (stuffed)
            add_predicted(1'b0, KIND_STUFF);
        if (fe)
        begin
            if (frame_words == COUNT_MAX)
                sat_frames++;
            while (frame_words < pad_target && pred_words.size() < PAD_MAX)
                add_predicted(1'b0, KIND_PAD);
            pred_words[pred_words.size()-1].last = 1'b1;
            ones_run    = '0;
            frame_words = '0;
        end
    endtask

    // Stop pushing until every expected word is out, then let the block settle
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pad_length(input logic [CNT_W-1:0] v);
        padded_length_wr <= 1'b1;
        padded_length    <= v;
        @(posedge clk);
        padded_length_wr <= 1'b0;
        pad_target = (v > PAD_MAX) ? CNT_W'(PAD_MAX) : v;
    endtask

    // Push one bit in bursts with random gaps
    task automatic send_bit(input logic d, input logic fe, input logic typed,
                            input logic t_stuff, input logic [CNT_W-1:0] t_pad);
        int gap;
        out_word_t w;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        push      <= 1'b1;
        data_bit  <= d;
        frame_end <= fe;
        do
            @(posedge clk);
        while (full);
        predict_stuffing(d, fe);
        if (typed)
        begin
            pred_words.delete();
            w.value = d;
            w.kind  = KIND_DATA;
            w.last  = 1'b0;
            pred_words.push_back(w);
            if (t_stuff)
            begin
                w.value = 1'b0;
                w.kind  = KIND_STUFF;
                pred_words.push_back(w);
            end
            w.value = 1'b0;
            w.kind  = KIND_PAD;
            repeat (t_pad) pred_words.push_back(w);
            if (fe)
                pred_words[pred_words.size()-1].last = 1'b1;
        end
        foreach (pred_words[i])
            expected_words.push_back(pred_words[i]);
        bits_accepted++;
        if (fe)
            frames_sent++;
        // hold off the sender once until the block is drained
        if (bits_accepted == HOLD_AT_WORD)
            wait_idle();
    endtask

    task automatic send_frame(input int len, input int style);
        logic d;
        for (int i = 0; i < len; i++)
        begin
            if (style == FRAME_NOISE)
                d = 1'($urandom_range(0, 1));
            else if (style == FRAME_STUFFED)
                d = ((i % 6) != 0);
            else
                d = ($urandom_range(0, 3) != 0);
            if (style == FRAME_PATTERN_END && i >= len - 6)
                d = (i != len - 6);
            send_bit(d, i == len - 1, 1'b0, 1'b0, '0);
        end
    endtask

    // Stimulus
    initial
    begin
        logic [CNT_W-1:0] phase_pads [6];
        int phase_bits;
        int style;
        int len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].is_cfg)
            begin
                wait_idle();
                write_pad_length(dir_rows[r].cfg_val);
            end
            else
                send_bit(dir_rows[r].d, dir_rows[r].fe, dir_rows[r].typed,
                         dir_rows[r].t_stuff, dir_rows[r].t_pad);
        end

        phase_pads[0] = 7'd1;
        phase_pads[1] = 7'd63;
        phase_pads[2] = 7'd100;
        phase_pads[3] = CNT_W'($urandom_range(2, 62));
        phase_pads[4] = 7'd0;
        phase_pads[5] = CNT_W'(PAD_MAX);

        foreach (phase_pads[p])
        begin
            wait_idle();
            write_pad_length(phase_pads[p]);
            gap_max = (p == 4) ? 0 : 6;
            phase_bits = 0;
            // a stuffing-heavy frame long enough to saturate the output counter
            if (p == 2)
            begin
                send_frame(LONG_FRAME, FRAME_STUFFED);
                phase_bits = LONG_FRAME;
            end
            while (phase_bits < PHASE_ITEMS)
            begin
                style = $urandom_range(0, 9);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24)
                                                  : $urandom_range(1, 10);
                if (style < 2)
                    style = FRAME_NOISE;
                else if (style < 4)
                begin
                    style = FRAME_PATTERN_END;
                    if (len < 6)
                        len = len + 6;
                end
                else
                    style = FRAME_BIASED;
                send_frame(len, style);
                phase_bits += len;
            end
        end

        wait_idle();
        $display("Sent %0d bits in %0d frames over several pad lengths; checked %0d words",
                 bits_accepted, frames_sent, words_checked);
        $display("Stuffed zeros %0d, pad zeros %0d, frames at counter limit %0d",
                 stuff_seen, pad_seen, sat_frames);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: check each popped word, then pick the next pop
    int        rx_mode   = RX_STREAM;
    int        mode_left = 0;
    logic [15:0] stall_pat = '1;
    out_word_t exp_word;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_bit %0b out_kind %0d out_last %0b",
                       out_bit, out_kind, out_last);
                mismatches++;
            end
            else
            begin
                exp_word = expected_words.pop_front();
                words_checked++;
                if (exp_word.kind == KIND_STUFF)
                    stuff_seen++;
                if (exp_word.kind == KIND_PAD)
                    pad_seen++;
                if (out_bit !== exp_word.value)
                begin
                    $error("out_bit: expected %0b, actual %0b", exp_word.value, out_bit);
                    mismatches++;
                end
                if (out_kind !== exp_word.kind)
                begin
                    $error("out_kind: expected %0d, actual %0d", exp_word.kind, out_kind);
                    mismatches++;
                end
                if (out_last !== exp_word.last)
                begin
                    $error("out_last: expected %0b, actual %0b", exp_word.last, out_last);
                    mismatches++;
                end
            end
        end

        // pick a new receiver mode and stall pattern when the current mode runs out
        if (mode_left == 0)
        begin
            rx_mode   = $urandom_range(RX_STREAM, RX_SPARSE);
            mode_left = $urandom_range(20, 120);
            stall_pat = 16'($urandom);
        end
        mode_left--;
        case (rx_mode)
            RX_STREAM:
                pop <= 1'b1;
            RX_PATTERN:
            begin
                pop <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
            default:
                pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

endmodule
